@@ hw/rtl/srtf_pkg.sv @@
// Shared constants and types for the shortest-remaining-time scheduler.
package srtf_pkg;

    localparam int NUM_PROCS  = 16;
    localparam int BURST_BITS = 16;
    localparam int IDX_BITS   = $clog2(NUM_PROCS);

    // largest remaining time a table entry holds
    localparam logic [32:0] BURST_MAX = (33'd1 << BURST_BITS) - 33'd1;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [BURST_BITS-1:0] burst_t;

endpackage

@@ hw/rtl/shortest_remaining_time_scheduler.sv @@
// Shortest-remaining-time-first scheduler: process table, scan sequencer, result register.
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_ready    mode, process_num, burst_len
//  result    out        result_valid / result_ready ran, running_num, finished, rejected
//
// An arrival's result is registered at the accepting edge.
// A tick steps through the accepting cycle, one remaining-time RAM read per entry,
// a drain state for the read latency, and write-back.
// Reset clears the pending bits, the state and the valid flags; the RAM needs no clearing pass.
// item_ready is high in idle while the result register is empty or being drained.
module shortest_remaining_time_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        mode,
    input  logic [3:0]  process_num,
    input  logic [15:0] burst_len,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        ran,
    output logic [3:0]  running_num,
    output logic        finished,
    output logic        rejected
);
    import srtf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam idx_t LAST_IDX = IDX_BITS'(NUM_PROCS - 1);

    logic [1:0]           state_reg, state_next;
    logic [NUM_PROCS-1:0] pending_reg, pending_next;
    idx_t                 rd_idx_reg, rd_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    idx_t                 cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    idx_t                 best_idx_reg, best_idx_next;
    burst_t               best_val_reg, best_val_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 ran_reg, ran_next;
    logic [3:0]           run_num_reg, run_num_next;
    logic                 fin_reg, fin_next;
    logic                 rej_reg, rej_next;

    logic   accept;
    logic   in_range;
    idx_t   arr_idx;
    burst_t burst_sat;
    logic   arr_reject;
    logic   arr_write;
    logic   take;
    logic   done_last;

    logic   ram_wr_en;
    idx_t   ram_wr_addr;
    burst_t ram_wr_data;
    logic   ram_rd_en;
    burst_t ram_rd_data;

    assign item_ready = (state_reg == ST_IDLE) && (!out_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    assign in_range   = 32'(process_num) < NUM_PROCS;
    assign arr_idx    = IDX_BITS'(process_num);
    assign burst_sat  = (33'(burst_len) > BURST_MAX) ? '1 : BURST_BITS'(burst_len);
    assign arr_reject = !in_range || (burst_len == 16'd0) || pending_reg[arr_idx];
    assign arr_write  = accept && (mode == MODE_ARRIVAL) && !arr_reject;

    // strict less-than keeps the lower number on a tie
    assign take = cmp_valid_reg && cmp_pend_reg &&
                  (!found_reg || (ram_rd_data < best_val_reg));

    assign done_last = (best_val_reg <= BURST_BITS'(1));

    // writes happen only in idle or write-back, reads only in scan: no overlap
    assign ram_rd_en   = (state_reg == ST_SCAN);
    assign ram_wr_en   = arr_write || ((state_reg == ST_DONE) && found_reg);
    assign ram_wr_addr = (state_reg == ST_DONE) ? best_idx_reg : arr_idx;
    assign ram_wr_data = (state_reg == ST_DONE) ? (best_val_reg - BURST_BITS'(1)) : burst_sat;

    srtf_ram #(
        .WIDTH (BURST_BITS),
        .DEPTH (NUM_PROCS)
    ) u_remaining (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_pend_next  = cmp_pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        out_valid_next = out_valid_reg && !result_ready;
        ran_next       = ran_reg;
        run_num_next   = run_num_reg;
        fin_next       = fin_reg;
        rej_next       = rej_reg;

        if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_val_next = ram_rd_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        state_next  = ST_SCAN;
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        ran_next       = 1'b0;
                        run_num_next   = 4'd0;
                        fin_next       = 1'b0;
                        rej_next       = arr_reject;
                        if (!arr_reject)
                        begin
                            pending_next[arr_idx] = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg;
                cmp_pend_next  = pending_reg[rd_idx_reg];
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                ran_next       = found_reg;
                run_num_next   = found_reg ? 4'(best_idx_reg) : 4'd0;
                fin_next       = found_reg && done_last;
                rej_next       = 1'b0;
                if (found_reg && done_last)
                begin
                    pending_next[best_idx_reg] = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cmp_pend_reg <= cmp_pend_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        ran_reg      <= ran_next;
        run_num_reg  <= run_num_next;
        fin_reg      <= fin_next;
        rej_reg      <= rej_next;
    end

    assign result_valid = out_valid_reg;
    assign ran          = ran_reg;
    assign running_num  = run_num_reg;
    assign finished     = fin_reg;
    assign rejected     = rej_reg;

`ifndef NO_ASSERTIONS
    // the result register stays empty for the whole tick scan
    a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !out_valid_reg)
        else $error("result register filled during scan");

    // the chosen process must still be pending at write-back
    a_best_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg) |-> pending_reg[best_idx_reg])
        else $error("selected process not pending");

    // an accepted arrival leaves its slot pending
    a_arrival_sets: assert property (@(posedge clk) disable iff (!rst_n)
        arr_write |=> pending_reg[$past(arr_idx)])
        else $error("arrival did not set pending bit");

    // a beat never carries both a run and a rejection; finish implies run
    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(ran_reg && rej_reg) && (!fin_reg || ran_reg)))
        else $error("inconsistent result beat");
`endif

endmodule

@@ hw/rtl/srtf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ bench/shortest_remaining_time_scheduler_test.sv @@
// Self-checking bench for the shortest-remaining-time-first scheduler.
module shortest_remaining_time_scheduler_test;

    import srtf_pkg::*;

    localparam logic MODE_ARRIVE  = 1'b0;
    localparam logic MODE_TICK    = 1'b1;
    localparam int   RANDOM_JOBS  = 700;
    localparam int   PHASE_LEN    = 88;
    localparam int   SETTLE_CYCLES = 2 * NUM_PROCS + 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    typedef struct packed {
        logic        mode;
        logic [3:0]  num;
        logic [15:0] burst;
        logic        hold;
        idle_mode_e  phase;
    } job_item_t;

    typedef struct packed {
        logic       ran;
        logic [3:0] num;
        logic       finished;
        logic       rejected;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic        mode;
    logic [3:0]  process_num;
    logic [15:0] burst_len;
    logic        result_valid;
    logic        result_ready;
    logic        ran;
    logic [3:0]  running_num;
    logic        finished;
    logic        rejected;

    job_item_t     job_queue[$];
    sched_result_t outcomes_due[$];
    job_item_t     next_job;
    idle_mode_e    idle_phase;
    logic          in_beat;
    int            mismatches;
    int            results_seen;

    // scheduler table as the bench sees it
    logic   proc_pending[NUM_PROCS];
    burst_t proc_left[NUM_PROCS];

    shortest_remaining_time_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .process_num  (process_num),
        .burst_len    (burst_len),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ran          (ran),
        .running_num  (running_num),
        .finished     (finished),
        .rejected     (rejected)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // One scheduler step: an arrival that is not rejected enters the table, tick runs the shortest job.
    function automatic sched_result_t run_scheduler(input logic m, input logic [3:0] n,
                                                    input logic [15:0] b);
        sched_result_t r;
        logic          found;
        int            best;
        r     = '0;
        found = 1'b0;
        best  = 0;
        if (m == MODE_ARRIVE)
        begin
            if (int'(n) >= NUM_PROCS || b == '0 || proc_pending[n])
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                proc_pending[n] = 1'b1;
                proc_left[n]    = burst_t'(b);
            end
        end
        else
        begin
            for (int k = 0; k < NUM_PROCS; k++)
            begin
                // strict less-than keeps the lower number on a tie
                if (proc_pending[k] && (!found || proc_left[k] < proc_left[best]))
                begin
                    best  = k;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                r.ran = 1'b1;
                r.num = 4'(best);
                if (proc_left[best] <= 1)
                begin
                    proc_left[best]    = '0;
                    proc_pending[best] = 1'b0;
                    r.finished         = 1'b1;
                end
                else
                begin
                    proc_left[best] = proc_left[best] - 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic add_job(input logic m, input logic [3:0] n, input logic [15:0] b,
                           input logic h, input idle_mode_e ph);
        job_item_t j;
        j.mode  = m;
        j.num   = n;
        j.burst = b;
        j.hold  = h;
        j.phase = ph;
        job_queue.insert(job_queue.size(), j);
    endtask

    // driver: new beat only when the line is free or the last beat was taken
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || in_beat))
        begin
            if (job_queue.size() != 0
                && !(job_queue[0].hold && outcomes_due.size() != 0)
                && $urandom_range(99) >= ((job_queue[0].phase == IDLE_SENDER) ? 70 :
                                          (job_queue[0].phase == IDLE_BOTH) ? 17 : 0))
            begin
                next_job    = job_queue.pop_front();
                idle_phase  = next_job.phase;
                mode        <= next_job.mode;
                process_num <= next_job.num;
                burst_len   <= next_job.burst;
                item_valid  <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_ready <= $urandom_range(99) >= ((idle_phase == IDLE_RECEIVER) ? 70 :
                                                   (idle_phase == IDLE_BOTH) ? 17 : 0);
    end

    // monitor: pop the result first, then predict the item taken on this edge
    always @(posedge clk)
    begin
        sched_result_t want;
        in_beat <= rst_n && item_valid && item_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (outcomes_due.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (ran !== want.ran)
                        flag_mismatch($sformatf("result %0d ran got %b want %b",
                                                results_seen, ran, want.ran));
                    if (running_num !== want.num)
                        flag_mismatch($sformatf("result %0d running_num got %0d want %0d",
                                                results_seen, running_num, want.num));
                    if (finished !== want.finished)
                        flag_mismatch($sformatf("result %0d finished got %b want %b",
                                                results_seen, finished, want.finished));
                    if (rejected !== want.rejected)
                        flag_mismatch($sformatf("result %0d rejected got %b want %b",
                                                results_seen, rejected, want.rejected));
                end
            end
            if (item_valid && item_ready)
                outcomes_due.insert(outcomes_due.size(),
                                    run_scheduler(mode, process_num, burst_len));
        end
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int         roll;
        logic [15:0] b;
        idle_mode_e ph;

        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        result_ready = 1'b0;
        mode         = MODE_ARRIVE;
        process_num  = '0;
        burst_len    = '0;
        in_beat      = 1'b0;
        idle_phase   = IDLE_NONE;
        mismatches   = 0;
        results_seen = 0;
        for (int k = 0; k < NUM_PROCS; k++)
        begin
            proc_pending[k] = 1'b0;
            proc_left[k]    = '0;
        end

        // directed: idle tick, rejects, tie, preemption, re-entry, widest burst
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd0,  16'd3,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd0,  16'd2,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd15, 16'd3,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd15, 16'hFFFF,  1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd7,  16'd1,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd0,  16'd1,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd15, 16'hFFFF,  1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_ARRIVE, 4'd3,  16'd2,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd0,  16'd0,     1'b0, IDLE_NONE);
        add_job(MODE_TICK,   4'd9,  16'hAAAA,  1'b0, IDLE_NONE);

        // random: mostly ticks with short bursts so jobs run to completion
        for (int i = 0; i < RANDOM_JOBS; i++)
        begin
            ph   = idle_mode_e'((i / PHASE_LEN) % 4);
            roll = $urandom_range(99);
            if (roll < 3)
                b = 16'd0;
            else if (roll < 5)
                b = 16'($urandom_range(65535));
            else if (roll < 25)
                b = 16'($urandom_range(16, 1));
            else
                b = 16'($urandom_range(4, 1));
            add_job(($urandom_range(99) < 78) ? MODE_TICK : MODE_ARRIVE,
                    4'($urandom_range(15)), b, (i % PHASE_LEN) == 0, ph);
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        wait (job_queue.size() == 0 && !item_valid && outcomes_due.size() == 0);
        // keep the receiver open so any stray beat shows up
        idle_phase = IDLE_NONE;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (outcomes_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ shortest_remaining_time_scheduler.f @@
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_ram.sv
hw/rtl/shortest_remaining_time_scheduler.sv
bench/shortest_remaining_time_scheduler_test.sv
